// ----- rtl/sensor_response_deframer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Sensor response deframer assertion macros
// Shared concurrent assertion forms used by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SENSOR_RESPONSE_DEFRAMER_TOP_DEFINES_SVH
`define SENSOR_RESPONSE_DEFRAMER_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define SRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed in the cycle after its trigger");

// The condition must hold at every clock edge outside reset.
`define SRD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deframer invariant violated");

`endif

// ----- rtl/srd_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor response deframer package
// Payload types, codes, state encoding and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_ARM  = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [2:0] KIND_RESPONSE = 3'd1;
    localparam logic [2:0] KIND_DATA     = 3'd2;
    localparam logic [2:0] KIND_CSUM_ERR = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_HEADER_CODE    = 3'd0;
    localparam logic [2:0] REG_DEVICE_ID      = 3'd1;
    localparam logic [2:0] REG_PACKET_KIND    = 3'd2;
    localparam logic [2:0] REG_DATA_LENGTH    = 3'd3;
    localparam logic [2:0] REG_CHECK_DATA_SUM = 3'd4;
    localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd5;

    // Register reset values.
    localparam logic [15:0] RST_HEADER_CODE    = 16'd21930;
    localparam logic [15:0] RST_DEVICE_ID      = 16'd1;
    localparam logic        RST_PACKET_KIND    = 1'b0;
    localparam logic [15:0] RST_DATA_LENGTH    = 16'd1;
    localparam logic        RST_CHECK_DATA_SUM = 1'b1;
    localparam logic [31:0] RST_TIMEOUT_TICKS  = 32'd1000;

    // Field lengths in bytes.
    localparam logic [15:0] PARAM_BYTES = 16'd4;
    localparam logic [15:0] CODE_BYTES  = 16'd2;
    localparam logic [15:0] WORD_BYTES  = 16'd2;

    // Framing phases, one-hot.
    typedef enum logic [6:0] {
        PH_HUNT     = 7'b0000001,
        PH_DEVID    = 7'b0000010,
        PH_PARAM    = 7'b0000100,
        PH_CODE     = 7'b0001000,
        PH_DATA     = 7'b0010000,
        PH_CSUM_CMD = 7'b0100000,
        PH_CSUM_DAT = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } srd_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [31:0] param_word;
        logic [15:0] response_code;
    } srd_out_t;

endpackage

`default_nettype wire

// ----- rtl/sensor_response_deframer_top.sv -----
// ----------------------------------------------------------------------------
// Sensor response deframer
// Frames sensor link bytes into payload, response, error and timeout results.
// ----------------------------------------------------------------------------
// Each accepted item (a received byte, a tick or an arm request) is handled by
// the framing state machine, and any result it causes is loaded into the
// output register in the same edge. A new item is taken every cycle;
// in_ready drops only while a result sits in the output register and out_ready
// is low. The configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_response_deframer_top_defines.svh"

module sensor_response_deframer_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire srd_pkg::srd_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output srd_pkg::srd_out_t     out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [31:0]      cfg_data
);

    import srd_pkg::*;

    // Configuration registers.
    logic [15:0] header_code_reg;
    logic [15:0] device_id_reg;
    logic        packet_kind_reg;
    logic [15:0] data_length_reg;
    logic        check_data_sum_reg;
    logic [31:0] timeout_ticks_reg;

    // Framing state.
    phase_t      phase_reg, phase_next;
    logic [15:0] header_shift_reg, header_shift_next;
    logic [15:0] field_count_reg, field_count_next;
    logic [15:0] id_word_reg, id_word_next;
    logic [31:0] param_reg, param_next;
    logic [15:0] code_reg, code_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0]  sum_low_byte_reg, sum_low_byte_next;
    logic        wait_armed_reg, wait_armed_next;
    logic [31:0] idle_ticks_reg, idle_ticks_next;

    // Output register.
    logic        out_valid_reg;
    srd_out_t    out_reg;

    // Per-item result.
    logic        res_valid;
    srd_out_t    res;

    logic        in_fire;
    logic [7:0]  b;
    logic [15:0] count_inc;
    logic [15:0] sum_add;
    logic [15:0] shift_cand;
    logic [15:0] id_cand;
    logic [15:0] got_sum;
    logic        sum_ok;
    logic [31:0] ticks_inc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign b          = in_data.rx_byte;
    assign count_inc  = field_count_reg + 16'd1;
    assign sum_add    = running_sum_reg + {8'd0, b};
    assign shift_cand = {header_shift_reg[7:0], b};
    assign id_cand    = {b, id_word_reg[15:8]};
    assign got_sum    = {b, sum_low_byte_reg};
    assign sum_ok     = (got_sum == running_sum_reg)
                        || (phase_reg == PH_CSUM_DAT && !check_data_sum_reg);
    assign ticks_inc  = (idle_ticks_reg == 32'hFFFF_FFFF) ? idle_ticks_reg
                                                          : idle_ticks_reg + 32'd1;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_code_reg    <= RST_HEADER_CODE;
            device_id_reg      <= RST_DEVICE_ID;
            packet_kind_reg    <= RST_PACKET_KIND;
            data_length_reg    <= RST_DATA_LENGTH;
            check_data_sum_reg <= RST_CHECK_DATA_SUM;
            timeout_ticks_reg  <= RST_TIMEOUT_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HEADER_CODE:    header_code_reg    <= cfg_data[15:0];
                REG_DEVICE_ID:      device_id_reg      <= cfg_data[15:0];
                REG_PACKET_KIND:    packet_kind_reg    <= cfg_data[0];
                REG_DATA_LENGTH:    data_length_reg    <= cfg_data[15:0];
                REG_CHECK_DATA_SUM: check_data_sum_reg <= cfg_data[0];
                REG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Framing state machine: next state and result for one item.
    always_comb
    begin
        phase_next        = phase_reg;
        header_shift_next = header_shift_reg;
        field_count_next  = field_count_reg;
        id_word_next      = id_word_reg;
        param_next        = param_reg;
        code_next         = code_reg;
        running_sum_next  = running_sum_reg;
        sum_low_byte_next = sum_low_byte_reg;
        wait_armed_next   = wait_armed_reg;
        idle_ticks_next   = idle_ticks_reg;
        res_valid         = 1'b0;
        res               = '0;

        case (in_data.op)
            OP_BYTE:
            begin
                idle_ticks_next = '0;
                case (phase_reg)
                    PH_HUNT:
                    begin
                        header_shift_next = shift_cand;
                        if (shift_cand == header_code_reg)
                        begin
                            running_sum_next  = {8'd0, header_code_reg[15:8]}
                                                + {8'd0, header_code_reg[7:0]};
                            header_shift_next = '0;
                            field_count_next  = '0;
                            phase_next        = PH_DEVID;
                        end
                    end
                    PH_DEVID:
                    begin
                        id_word_next     = id_cand;
                        running_sum_next = sum_add;
                        field_count_next = count_inc;
                        if (count_inc >= WORD_BYTES)
                        begin
                            field_count_next = '0;
                            if (id_cand != device_id_reg)
                            begin
                                phase_next        = PH_HUNT;
                                header_shift_next = '0;
                            end
                            else if (!packet_kind_reg)
                            begin
                                phase_next = PH_PARAM;
                            end
                            else if (data_length_reg == 16'd0)
                            begin
                                phase_next = PH_CSUM_DAT;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                    PH_PARAM:
                    begin
                        param_next       = {b, param_reg[31:8]};
                        running_sum_next = sum_add;
                        field_count_next = count_inc;
                        if (count_inc >= PARAM_BYTES)
                        begin
                            field_count_next = '0;
                            phase_next       = PH_CODE;
                        end
                    end
                    PH_CODE:
                    begin
                        code_next        = {b, code_reg[15:8]};
                        running_sum_next = sum_add;
                        field_count_next = count_inc;
                        if (count_inc >= CODE_BYTES)
                        begin
                            field_count_next = '0;
                            phase_next       = PH_CSUM_CMD;
                        end
                    end
                    PH_DATA:
                    begin
                        running_sum_next = sum_add;
                        field_count_next = count_inc;
                        // A wrapped count also ends the payload.
                        if (count_inc >= data_length_reg || count_inc == 16'd0)
                        begin
                            field_count_next = '0;
                            phase_next       = PH_CSUM_DAT;
                        end
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = b;
                    end
                    PH_CSUM_CMD, PH_CSUM_DAT:
                    begin
                        if (field_count_reg == 16'd0)
                        begin
                            sum_low_byte_next = b;
                            field_count_next  = 16'd1;
                        end
                        else
                        begin
                            phase_next        = PH_HUNT;
                            header_shift_next = '0;
                            field_count_next  = '0;
                            res_valid         = 1'b1;
                            if (!sum_ok)
                            begin
                                res.kind = KIND_CSUM_ERR;
                            end
                            else
                            begin
                                wait_armed_next = 1'b0;
                                if (phase_reg == PH_CSUM_CMD)
                                begin
                                    res.kind          = KIND_RESPONSE;
                                    res.param_word    = param_reg;
                                    res.response_code = code_reg;
                                end
                                else
                                begin
                                    res.kind = KIND_DATA;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        phase_next        = PH_HUNT;
                        header_shift_next = '0;
                        field_count_next  = '0;
                    end
                endcase
            end
            OP_TICK:
            begin
                if (wait_armed_reg)
                begin
                    idle_ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_ticks_reg)
                    begin
                        wait_armed_next   = 1'b0;
                        idle_ticks_next   = '0;
                        phase_next        = PH_HUNT;
                        header_shift_next = '0;
                        field_count_next  = '0;
                        res_valid         = 1'b1;
                        res.kind          = KIND_TIMEOUT;
                    end
                end
            end
            OP_ARM:
            begin
                wait_armed_next   = 1'b1;
                idle_ticks_next   = '0;
                phase_next        = PH_HUNT;
                header_shift_next = '0;
                field_count_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    // State update on each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            header_shift_reg <= '0;
            field_count_reg  <= '0;
            id_word_reg      <= '0;
            param_reg        <= '0;
            code_reg         <= '0;
            running_sum_reg  <= '0;
            sum_low_byte_reg <= '0;
            wait_armed_reg   <= 1'b0;
            idle_ticks_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            header_shift_reg <= header_shift_next;
            field_count_reg  <= field_count_next;
            id_word_reg      <= id_word_next;
            param_reg        <= param_next;
            code_reg         <= code_next;
            running_sum_reg  <= running_sum_next;
            sum_low_byte_reg <= sum_low_byte_next;
            wait_armed_reg   <= wait_armed_next;
            idle_ticks_reg   <= idle_ticks_next;
        end
    end

    // Output register: loads on an accepted item, drains when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg <= res;
        end
    end

    // Checks on the framing logic.
    `SRD_ASSERT_ALWAYS(a_phase_onehot, clk, rst_n, $onehot(phase_reg))
    `SRD_ASSERT_NEXT(a_arm_restarts, clk, rst_n, in_fire && in_data.op == OP_ARM, wait_armed_reg && phase_reg == PH_HUNT && idle_ticks_reg == 32'd0)
    `SRD_ASSERT_NEXT(a_done_disarms, clk, rst_n, in_fire && res_valid && (res.kind == KIND_RESPONSE || res.kind == KIND_DATA), !wait_armed_reg && phase_reg == PH_HUNT)
    `SRD_ASSERT_ALWAYS(a_code_count, clk, rst_n, phase_reg != PH_CODE || field_count_reg < CODE_BYTES)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor response deframer testbench
// Streams received bytes, ticks and arm requests into the deframer, keeps a
// cycle-free shadow of its framing state and compares every result against
// it. Configuration is changed between traffic phases, and both handshakes
// are paced with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
    import srd_pkg::*;

    // Codes the package leaves unnamed: the spare operation and the unused
    // register slots.
    localparam logic [1:0] OP_SPARE     = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int CLK_HALF           = 6;
    localparam int LIMIT_CYCLES       = 1_000_000;
    localparam int RANDOM_PER_SETTING = 100;
    localparam int REPORT_LIMIT       = 10;

    // Shadow of the framer: register copies, framing state and the queue of
    // results that accepted requests have caused but the block has not yet
    // delivered.
    class packet_tracker;
        logic [15:0] hdr_code;
        logic [15:0] dev_id;
        logic        kind_sel;
        logic [15:0] data_len;
        logic        sum_check;
        logic [31:0] tick_limit;

        phase_t      ph;
        logic [15:0] hunt_shift;
        logic [15:0] byte_count;
        logic [15:0] id_acc;
        logic [31:0] param_acc;
        logic [15:0] code_acc;
        logic [15:0] sum_acc;
        logic [7:0]  sum_lo;
        logic        armed;
        logic [31:0] ticks;

        srd_out_t    due_results[$];
        int          failures;
        int          kind_seen[5];

        function new();
            hdr_code   = RST_HEADER_CODE;
            dev_id     = RST_DEVICE_ID;
            kind_sel   = RST_PACKET_KIND;
            data_len   = RST_DATA_LENGTH;
            sum_check  = RST_CHECK_DATA_SUM;
            tick_limit = RST_TIMEOUT_TICKS;
            ph         = PH_HUNT;
            hunt_shift = '0;
            byte_count = '0;
            id_acc     = '0;
            param_acc  = '0;
            code_acc   = '0;
            sum_acc    = '0;
            sum_lo     = '0;
            armed      = 1'b0;
            ticks      = '0;
            failures   = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_HEADER_CODE:    hdr_code   = val[15:0];
                REG_DEVICE_ID:      dev_id     = val[15:0];
                REG_PACKET_KIND:    kind_sel   = val[0];
                REG_DATA_LENGTH:    data_len   = val[15:0];
                REG_CHECK_DATA_SUM: sum_check  = val[0];
                REG_TIMEOUT_TICKS:  tick_limit = val;
                default: ;
            endcase
        endfunction

        function void restart_hunt();
            ph         = PH_HUNT;
            hunt_shift = '0;
            byte_count = '0;
        endfunction

        function void queue_result(logic [2:0] kind, logic [7:0] pb, logic [31:0] pw,
                                   logic [15:0] rc);
            srd_out_t r;
            r.kind          = kind;
            r.payload_byte  = pb;
            r.param_word    = pw;
            r.response_code = rc;
            due_results.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b);
            logic [15:0] got;
            ticks = '0;
            case (ph)
                PH_HUNT:
                begin
                    hunt_shift = {hunt_shift[7:0], b};
                    if (hunt_shift == hdr_code)
                    begin
                        sum_acc    = {8'h00, hdr_code[15:8]} + {8'h00, hdr_code[7:0]};
                        hunt_shift = '0;
                        byte_count = '0;
                        ph         = PH_DEVID;
                    end
                end
                PH_DEVID:
                begin
                    id_acc     = {b, id_acc[15:8]};
                    sum_acc    = sum_acc + {8'h00, b};
                    byte_count = byte_count + 16'd1;
                    if (byte_count >= WORD_BYTES)
                    begin
                        byte_count = '0;
                        // The packet kind is latched here, once the id matches.
                        if (id_acc != dev_id)
                            restart_hunt();
                        else if (!kind_sel)
                            ph = PH_PARAM;
                        else if (data_len == 16'd0)
                            ph = PH_CSUM_DAT;
                        else
                            ph = PH_DATA;
                    end
                end
                PH_PARAM:
                begin
                    param_acc  = {b, param_acc[31:8]};
                    sum_acc    = sum_acc + {8'h00, b};
                    byte_count = byte_count + 16'd1;
                    if (byte_count >= PARAM_BYTES)
                    begin
                        byte_count = '0;
                        ph         = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    code_acc   = {b, code_acc[15:8]};
                    sum_acc    = sum_acc + {8'h00, b};
                    byte_count = byte_count + 16'd1;
                    if (byte_count >= CODE_BYTES)
                    begin
                        byte_count = '0;
                        ph         = PH_CSUM_CMD;
                    end
                end
                PH_DATA:
                begin
                    sum_acc    = sum_acc + {8'h00, b};
                    byte_count = byte_count + 16'd1;
                    // A length lowered mid-packet ends the payload at once.
                    if (byte_count >= data_len || byte_count == 16'd0)
                    begin
                        byte_count = '0;
                        ph         = PH_CSUM_DAT;
                    end
                    queue_result(KIND_PAYLOAD, b, '0, '0);
                end
                PH_CSUM_CMD, PH_CSUM_DAT:
                begin
                    if (byte_count == 16'd0)
                    begin
                        sum_lo     = b;
                        byte_count = 16'd1;
                    end
                    else
                    begin
                        got = {b, sum_lo};
                        if (got != sum_acc && !(ph == PH_CSUM_DAT && !sum_check))
                        begin
                            // A bad checksum leaves the wait armed.
                            restart_hunt();
                            queue_result(KIND_CSUM_ERR, '0, '0, '0);
                        end
                        else
                        begin
                            if (ph == PH_CSUM_CMD)
                                queue_result(KIND_RESPONSE, '0, param_acc, code_acc);
                            else
                                queue_result(KIND_DATA, '0, '0, '0);
                            restart_hunt();
                            armed = 1'b0;
                        end
                    end
                end
                default: restart_hunt();
            endcase
        endfunction

        function void note_request(srd_in_t req);
            case (req.op)
                OP_BYTE: take_byte(req.rx_byte);
                OP_TICK:
                begin
                    if (armed)
                    begin
                        if (ticks != '1)
                            ticks = ticks + 32'd1;
                        if (ticks >= tick_limit)
                        begin
                            armed = 1'b0;
                            ticks = '0;
                            restart_hunt();
                            queue_result(KIND_TIMEOUT, '0, '0, '0);
                        end
                    end
                end
                OP_ARM:
                begin
                    armed = 1'b1;
                    ticks = '0;
                    restart_hunt();
                end
                default: ;
            endcase
        endfunction

        function void check_result(srd_out_t got);
            srd_out_t want;
            if (due_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("ERROR: unexpected result kind=%0d byte=%02h param=%08h code=%04h",
                             got.kind, got.payload_byte, got.param_word, got.response_code);
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                got.param_word !== want.param_word ||
                got.response_code !== want.response_code)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("ERROR: expected kind=%0d byte=%02h param=%08h code=%04h",
                             want.kind, want.payload_byte, want.param_word,
                             want.response_code);
                    $display("       actual   kind=%0d byte=%02h param=%08h code=%04h",
                             got.kind, got.payload_byte, got.param_word, got.response_code);
                end
            end
            else if (want.kind <= KIND_TIMEOUT)
                kind_seen[want.kind]++;
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    srd_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    srd_out_t out_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int cfg_writes     = 0;

    packet_tracker tracker;

    sensor_response_deframer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Result side back-pressure, redrawn every cycle.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check delivered results first, then record the request taken at the
    // same edge; a result can never belong to a request accepted at that edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_result(out_data);
            if (in_valid && in_ready)
                tracker.note_request(in_data);
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Run timed out with %0d results still outstanding.",
                 tracker.due_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one request, after a random number of idle cycles.
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        srd_in_t req;
        req.op      = op;
        req.rx_byte = b;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Stop sending and let every outstanding result drain out.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_reg(idx, val);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] frame_sum(input logic [7:0] frame[$]);
        logic [15:0] acc;
        acc = '0;
        foreach (frame[i]) acc = acc + {8'h00, frame[i]};
        return acc;
    endfunction

    // Send bytes first..stop-1 of a frame, with ticks slipped in between.
    task automatic send_frame(input logic [7:0] frame[$], input int first, input int stop,
                              input int tick_pct);
        for (int i = first; i < stop; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                send_item(OP_TICK, 8'($urandom));
            send_item(OP_BYTE, frame[i]);
        end
    endtask

    // Build a packet of the configured kind with random content; optionally
    // cut short, with a foreign device id or with a spoiled checksum.
    task automatic send_packet(input int cut, input bit wrong_id, input bit bad_sum,
                               input int tick_pct);
        logic [7:0]  frame[$];
        logic [15:0] id;
        logic [15:0] total;
        int          body;
        int          stop;
        id = tracker.dev_id;
        if (wrong_id)
            id = id ^ 16'($urandom_range(1, 65535));
        frame.push_back(tracker.hdr_code[15:8]);
        frame.push_back(tracker.hdr_code[7:0]);
        frame.push_back(id[7:0]);
        frame.push_back(id[15:8]);
        body = tracker.kind_sel ? int'(tracker.data_len) : int'(PARAM_BYTES + CODE_BYTES);
        repeat (body) frame.push_back(8'($urandom));
        total = frame_sum(frame);
        if (bad_sum)
            total = total ^ 16'($urandom_range(1, 65535));
        frame.push_back(total[7:0]);
        frame.push_back(total[15:8]);
        stop = (cut >= 0 && cut < frame.size()) ? cut : frame.size();
        send_frame(frame, 0, stop, tick_pct);
    endtask

    // Ticks enough to reach a short timeout, or a few against a long one.
    task automatic send_ticks();
        int count;
        if (tracker.tick_limit <= 32'd8)
            count = int'(tracker.tick_limit) + $urandom_range(0, 1);
        else
            count = $urandom_range(1, 10);
        repeat (count) send_item(OP_TICK, 8'($urandom));
    endtask

    task automatic run_episode();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom));
            send_packet(-1, $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 15, 8);
        end
        else if (pick < 65)
        begin
            send_item(OP_ARM, 8'($urandom));
            send_ticks();
        end
        else if (pick < 80)
        begin
            // Armed wait across a packet; a bad checksum keeps it armed.
            send_item(OP_ARM, 8'($urandom));
            send_packet(-1, 1'b0, $urandom_range(0, 99) < 30, 0);
            send_ticks();
        end
        else if (pick < 90)
            send_packet($urandom_range(1, 8), 1'b0, 1'b0, 0);
        else
            repeat ($urandom_range(1, 6))
                send_item(2'($urandom_range(0, 3)), 8'($urandom));
    endtask

    // Register values for one traffic phase; the extremes rotate through.
    task automatic apply_setting(input int s);
        logic [15:0] hdr;
        logic [15:0] id;
        logic [15:0] len;
        logic [31:0] limit;
        case (s % 4)
            0:       hdr = 16'h0000;
            1:       hdr = 16'hFFFF;
            2:       hdr = RST_HEADER_CODE;
            default: hdr = 16'($urandom);
        endcase
        case (s % 3)
            0:       id = 16'h0000;
            1:       id = 16'hFFFF;
            default: id = 16'($urandom);
        endcase
        case ((s + 1) % 4)
            0:       len = 16'd0;
            1:       len = 16'd1;
            default: len = 16'($urandom_range(2, 12));
        endcase
        case ((s + 2) % 4)
            0:       limit = 32'd0;
            1:       limit = 32'd1;
            2:       limit = 32'($urandom_range(2, 6));
            default: limit = 32'hFFFF_FFFF;
        endcase
        write_reg(REG_HEADER_CODE, {16'($urandom), hdr});
        write_reg(REG_DEVICE_ID, {16'($urandom), id});
        write_reg(REG_PACKET_KIND, 32'((s + s / 4) % 2));
        write_reg(REG_DATA_LENGTH, {16'($urandom), len});
        write_reg(REG_CHECK_DATA_SUM, 32'((s / 2) % 2));
        write_reg(REG_TIMEOUT_TICKS, limit);
        if (s == 3)
        begin
            write_reg(REG_SPARE_LO, $urandom);
            write_reg(REG_SPARE_HI, $urandom);
        end
    endtask

    initial
    begin
        logic [7:0]  frame[$];
        logic [15:0] total;
        int          goal;

        tracker = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: good command response with extreme bytes under reset values.
        send_item(OP_ARM, 8'h00);
        frame = '{RST_HEADER_CODE[15:8], RST_HEADER_CODE[7:0], RST_DEVICE_ID[7:0],
                  RST_DEVICE_ID[15:8], 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h00, 8'hFF};
        total = frame_sum(frame);
        frame.push_back(total[7:0]);
        frame.push_back(total[15:8]);
        send_frame(frame, 0, frame.size(), 0);

        // The wait is now disarmed, so the tick is ignored, as is the spare op.
        send_item(OP_TICK, 8'hFF);
        send_item(OP_SPARE, 8'h5A);

        // A zero timeout fires on the first armed tick.
        settle();
        write_reg(REG_TIMEOUT_TICKS, 32'd0);
        send_item(OP_ARM, 8'h00);
        send_item(OP_TICK, 8'h00);

        // Packet kind switched after the id: the data packet must carry on.
        settle();
        write_reg(REG_PACKET_KIND, 32'd1);
        write_reg(REG_DATA_LENGTH, 32'd2);
        frame = '{RST_HEADER_CODE[15:8], RST_HEADER_CODE[7:0], RST_DEVICE_ID[7:0],
                  RST_DEVICE_ID[15:8], 8'h00, 8'hFF};
        total = frame_sum(frame);
        frame.push_back(total[7:0]);
        frame.push_back(total[15:8]);
        send_frame(frame, 0, 4, 0);
        settle();
        write_reg(REG_PACKET_KIND, 32'd0);
        send_frame(frame, 4, frame.size(), 0);

        // Length lowered below the bytes already taken ends the payload early.
        settle();
        write_reg(REG_PACKET_KIND, 32'd1);
        write_reg(REG_DATA_LENGTH, 32'd6);
        frame = '{RST_HEADER_CODE[15:8], RST_HEADER_CODE[7:0], RST_DEVICE_ID[7:0],
                  RST_DEVICE_ID[15:8], 8'h11, 8'h22, 8'h33, 8'h44};
        total = frame_sum(frame);
        frame.push_back(total[7:0]);
        frame.push_back(total[15:8]);
        send_frame(frame, 0, 7, 0);
        settle();
        write_reg(REG_DATA_LENGTH, 32'd2);
        send_frame(frame, 7, frame.size(), 0);

        // Random traffic in four pacing phases, two register settings each.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 47;
                end
                default:
                begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase
            for (int k = 0; k < 2; k++)
            begin
                settle();
                apply_setting(p * 2 + k);
                goal = items_sent + RANDOM_PER_SETTING;
                while (items_sent < goal)
                    run_episode();
            end
        end

        settle();
        repeat (8) @(posedge clk);

        $display("Sent %0d requests and %0d register writes across four pacing phases.",
                 items_sent, cfg_writes);
        $display("Checked %0d payload, %0d response, %0d data, %0d checksum error, %0d timeout.",
                 tracker.kind_seen[KIND_PAYLOAD], tracker.kind_seen[KIND_RESPONSE],
                 tracker.kind_seen[KIND_DATA], tracker.kind_seen[KIND_CSUM_ERR],
                 tracker.kind_seen[KIND_TIMEOUT]);
        if (tracker.failures == 0 && tracker.due_results.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d expected results never delivered.",
                     tracker.failures, tracker.due_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
